/* rtl/ofp_pkg.sv */
// Package for the optical flow frame parser: frame byte constants and shared types.
// No dependencies.
`default_nettype none

package ofp_pkg;

    localparam logic [7:0] FRAME_HEADER = 8'hFE;
    localparam logic [7:0] FRAME_LENGTH = 8'h04;
    localparam logic [7:0] FRAME_FOOTER = 8'hAA;

    localparam logic [15:0] FLOW_SCALE_RESET = 16'd231;

    typedef struct packed {
        logic signed [31:0] flow_x;
        logic signed [31:0] flow_y;
        logic [7:0]         quality;
    } flow_result_t;

    // Status of the result register as seen by the parser
    typedef struct packed {
        logic full;
        logic stall;
    } out_status_t;

endpackage

`default_nettype wire

/* rtl/ofp_parser.sv */
// Frame state machine, motion byte store, checksum and flow scaling.
// Depends on ofp_pkg.
`default_nettype none

module ofp_parser (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 rx_valid,
    input  wire logic [7:0]           rx_byte,
    input  wire logic [15:0]          flow_scale,
    input  wire ofp_pkg::out_status_t out_status,
    output logic                      rx_stall,
    output logic                      emit,
    output ofp_pkg::flow_result_t     result
);

    typedef enum logic [3:0] {
        ST_HUNT = 4'd0,
        ST_HDR  = 4'd1,
        ST_LEN  = 4'd2,
        ST_XL   = 4'd3,
        ST_XH   = 4'd4,
        ST_YL   = 4'd5,
        ST_YH   = 4'd6,
        ST_CKS  = 4'd7,
        ST_QUAL = 4'd8,
        ST_FOOT = 4'd9
    } state_t;

    state_t             state_reg, state_next;
    logic [7:0]         motion_reg [4];
    logic signed [31:0] held_x_reg, held_x_next;
    logic signed [31:0] held_y_reg, held_y_next;
    logic [7:0]         held_quality_reg, held_quality_next;

    logic               accept;
    logic [7:0]         checksum;
    logic signed [32:0] prod_x;
    logic signed [32:0] prod_y;

    // Only the footer byte can produce a result; hold it off while the result is stuck.
    assign rx_stall = (state_reg == ST_QUAL) && out_status.full && out_status.stall;
    assign accept   = rx_valid && !rx_stall;

    assign checksum = motion_reg[0] + motion_reg[1] + motion_reg[2] + motion_reg[3];
    assign prod_x   = $signed({motion_reg[1], motion_reg[0]}) * $signed({1'b0, flow_scale});
    assign prod_y   = $signed({motion_reg[3], motion_reg[2]}) * $signed({1'b0, flow_scale});

    always_comb
    begin
        state_next        = state_reg;
        held_x_next       = held_x_reg;
        held_y_next       = held_y_reg;
        held_quality_next = held_quality_reg;
        emit              = 1'b0;
        if (accept)
        begin
            unique case (state_reg)
                ST_HDR:  state_next = (rx_byte == ofp_pkg::FRAME_LENGTH) ? ST_LEN : ST_HUNT;
                ST_LEN:  state_next = ST_XL;
                ST_XL:   state_next = ST_XH;
                ST_XH:   state_next = ST_YL;
                ST_YL:   state_next = ST_YH;
                ST_YH:
                begin
                    if (rx_byte == checksum)
                    begin
                        held_x_next = prod_x[31:0];
                        held_y_next = prod_y[31:0];
                        state_next  = ST_CKS;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                    end
                end
                ST_CKS:
                begin
                    held_quality_next = rx_byte;
                    state_next        = ST_QUAL;
                end
                ST_QUAL:
                begin
                    if (rx_byte == ofp_pkg::FRAME_FOOTER)
                    begin
                        emit       = 1'b1;
                        state_next = ST_FOOT;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                    end
                end
                // hunt, footer and unused codes all look for a header
                default: state_next = (rx_byte == ofp_pkg::FRAME_HEADER) ? ST_HDR : ST_HUNT;
            endcase
        end
    end

    assign result.flow_x  = held_x_reg;
    assign result.flow_y  = held_y_reg;
    assign result.quality = held_quality_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_HUNT;
            held_x_reg       <= '0;
            held_y_reg       <= '0;
            held_quality_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            held_x_reg       <= held_x_next;
            held_y_reg       <= held_y_next;
            held_quality_reg <= held_quality_next;
        end
    end

    // Motion bytes go to fixed slots by state; no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            case (state_reg)
                ST_LEN:  motion_reg[0] <= rx_byte;
                ST_XL:   motion_reg[1] <= rx_byte;
                ST_XH:   motion_reg[2] <= rx_byte;
                ST_YL:   motion_reg[3] <= rx_byte;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/ofp_out.sv */
// Result register for the flow output channel.
// Depends on ofp_pkg.
`default_nettype none

module ofp_out (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  emit,
    input  wire ofp_pkg::flow_result_t result,
    input  wire logic                  flow_stall,
    output logic                       flow_valid,
    output ofp_pkg::flow_result_t      flow_data,
    output ofp_pkg::out_status_t       out_status
);

    logic                  valid_reg, valid_next;
    ofp_pkg::flow_result_t data_reg;

    assign valid_next = emit || (valid_reg && flow_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            data_reg <= result;
        end
    end

    assign flow_valid       = valid_reg;
    assign flow_data        = data_reg;
    assign out_status.full  = valid_reg;
    assign out_status.stall = flow_stall;

endmodule

`default_nettype wire

/* rtl/optical_flow_frame_parser_top.sv */
// Top level of the optical flow frame parser: config register, parser and result register.
// Depends on ofp_pkg, ofp_parser and ofp_out.
// Throughput: one received byte per cycle unless rx_stall holds the footer byte; a frame takes nine bytes.
// The result is registered: flow_valid rises in the cycle after the footer byte is accepted.
// A byte in the quality-to-footer position stalls only while a prior result is unread.
// Reset (rst_n low, async) returns to header hunt, clears held values, flow_scale = 231.
`default_nettype none

module optical_flow_frame_parser_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               rx_valid,
    output logic                    rx_stall,
    input  wire logic [7:0]         rx_byte,
    output logic                    flow_valid,
    input  wire logic               flow_stall,
    output logic signed [31:0]      flow_x,
    output logic signed [31:0]      flow_y,
    output logic [7:0]              quality,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [15:0]        cfg_data
);

    logic [15:0]           flow_scale_reg;
    logic                  emit;
    ofp_pkg::flow_result_t result;
    ofp_pkg::flow_result_t flow_data;
    ofp_pkg::out_status_t  out_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_scale_reg <= ofp_pkg::FLOW_SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            flow_scale_reg <= cfg_data;
        end
    end

    ofp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_byte    (rx_byte),
        .flow_scale (flow_scale_reg),
        .out_status (out_status),
        .rx_stall   (rx_stall),
        .emit       (emit),
        .result     (result)
    );

    ofp_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit       (emit),
        .result     (result),
        .flow_stall (flow_stall),
        .flow_valid (flow_valid),
        .flow_data  (flow_data),
        .out_status (out_status)
    );

    assign flow_x  = flow_data.flow_x;
    assign flow_y  = flow_data.flow_y;
    assign quality = flow_data.quality;

endmodule

`default_nettype wire

/* rtl/ofp_checker.sv */
// Port-level checks for the optical flow frame parser, bound to the top level.
// Depends on ofp_pkg and optical_flow_frame_parser_top.
`default_nettype none

module ofp_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               rx_valid,
    input wire logic               rx_stall,
    input wire logic [7:0]         rx_byte,
    input wire logic               flow_valid,
    input wire logic               flow_stall,
    input wire logic signed [31:0] flow_x,
    input wire logic signed [31:0] flow_y,
    input wire logic [7:0]         quality
);

    // a stalled result request stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        flow_valid && flow_stall |=> flow_valid)
        else $error("flow_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        flow_valid && flow_stall |=> $stable(flow_x) && $stable(flow_y) && $stable(quality))
        else $error("flow payload changed while stalled");

    // a new result only follows an accepted footer byte
    a_footer: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(flow_valid) |->
            $past(rx_valid && !rx_stall && rx_byte == ofp_pkg::FRAME_FOOTER))
        else $error("result without footer");

    // the input side only backs up behind an unread result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> flow_valid && flow_stall)
        else $error("rx_stall without a pending result");

endmodule

bind optical_flow_frame_parser_top ofp_checker u_ofp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_byte    (rx_byte),
    .flow_valid (flow_valid),
    .flow_stall (flow_stall),
    .flow_x     (flow_x),
    .flow_y     (flow_y),
    .quality    (quality)
);

`default_nettype wire

/* bench/tb_optical_flow_frame_parser_top.sv */
// Testbench for optical_flow_frame_parser_top: feeds serial frame bytes, predicts scaled flow.
// Depends on ofp_pkg and the RTL top level, which in turn needs ofp_parser and ofp_out.
// Directed frames and error cases first, then random phases with random scales and idling.
`timescale 1ns / 100ps

module tb_optical_flow_frame_parser_top;

    localparam int unsigned RANDOM_BYTES = 1100;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned MAX_WAIT     = 6;

    // Next byte the frame tracker is looking for
    typedef enum logic [3:0] {
        WANT_HDR, WANT_LEN, WANT_XL, WANT_XH, WANT_YL, WANT_YH,
        WANT_CKS, WANT_QUAL, WANT_FOOT, AFTER_FOOT
    } frame_pos_t;

    typedef enum logic [1:0] {FLAW_NONE, FLAW_LEN, FLAW_CKS, FLAW_FOOT} flaw_t;

    logic               clk;
    logic               rst_n;
    logic               rx_valid;
    logic               rx_stall;
    logic [7:0]         rx_byte;
    logic               flow_valid;
    logic               flow_stall;
    logic signed [31:0] flow_x;
    logic signed [31:0] flow_y;
    logic [7:0]         quality;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [15:0]        cfg_data;

    // Predictor state
    frame_pos_t            frame_pos;
    logic [7:0]            motion [4];
    logic [15:0]           scale_now;
    ofp_pkg::flow_result_t held_flow;
    ofp_pkg::flow_result_t expected_flows [$];

    bit          rx_gaps_on;
    bit          out_stall_on;
    int unsigned rx_count;
    int unsigned fail_count;
    int unsigned cycle_count;

    optical_flow_frame_parser_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .rx_byte    (rx_byte),
        .flow_valid (flow_valid),
        .flow_stall (flow_stall),
        .flow_x     (flow_x),
        .flow_y     (flow_y),
        .quality    (quality),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_optical_flow_frame_parser_top: errors");
            $finish;
        end
    end

    function automatic int unsigned draw_wait(input bit enabled);
        return enabled ? $urandom_range(0, MAX_WAIT) : 0;
    endfunction

    function automatic logic signed [31:0] scale_count(input logic [15:0] raw);
        longint prod;
        prod = longint'($signed(raw)) * longint'(scale_now);
        return prod[31:0];
    endfunction

    // Advance the frame tracker by one accepted byte
    task automatic track_byte(input logic [7:0] b);
        logic [7:0] sum;
        case (frame_pos)
            WANT_LEN:  frame_pos = (b == ofp_pkg::FRAME_LENGTH) ? WANT_XL : WANT_HDR;
            WANT_XL:
            begin
                motion[0] = b;
                frame_pos = WANT_XH;
            end
            WANT_XH:
            begin
                motion[1] = b;
                frame_pos = WANT_YL;
            end
            WANT_YL:
            begin
                motion[2] = b;
                frame_pos = WANT_YH;
            end
            WANT_YH:
            begin
                motion[3] = b;
                frame_pos = WANT_CKS;
            end
            WANT_CKS:
            begin
                sum = motion[0] + motion[1] + motion[2] + motion[3];
                if (b == sum)
                begin
                    // product uses the scale in force when the checksum lands
                    held_flow.flow_x = scale_count({motion[1], motion[0]});
                    held_flow.flow_y = scale_count({motion[3], motion[2]});
                    frame_pos = WANT_QUAL;
                end
                else
                    frame_pos = WANT_HDR;
            end
            WANT_QUAL:
            begin
                held_flow.quality = b;
                frame_pos = WANT_FOOT;
            end
            WANT_FOOT:
            begin
                if (b == ofp_pkg::FRAME_FOOTER)
                begin
                    expected_flows.push_back(held_flow);
                    frame_pos = AFTER_FOOT;
                end
                else
                    frame_pos = WANT_HDR;
            end
            default:   frame_pos = (b == ofp_pkg::FRAME_HEADER) ? WANT_LEN : WANT_HDR;
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = draw_wait(rx_gaps_on);
        if (gap != 0)
        begin
            rx_valid = 1'b0;
            rx_byte  = 8'($urandom);
            repeat (gap) @(negedge clk);
        end
        rx_valid = 1'b1;
        rx_byte  = b;
        do @(posedge clk); while (rx_stall);
        track_byte(b);
        rx_count++;
        @(negedge clk);
    endtask

    // Frame packed header first: bits 71:64 hold the header byte
    function automatic logic [71:0] frame_word(input logic [15:0] dx, input logic [15:0] dy,
                                               input logic [7:0] q, input flaw_t flaw);
        logic [7:0] len;
        logic [7:0] cks;
        logic [7:0] ftr;
        len = ofp_pkg::FRAME_LENGTH;
        cks = dx[7:0] + dx[15:8] + dy[7:0] + dy[15:8];
        ftr = ofp_pkg::FRAME_FOOTER;
        case (flaw)
            FLAW_LEN:  len = len ^ 8'($urandom_range(1, 255));
            FLAW_CKS:  cks = cks ^ 8'($urandom_range(1, 255));
            FLAW_FOOT: ftr = ftr ^ 8'($urandom_range(1, 255));
            default:   ;
        endcase
        return {ofp_pkg::FRAME_HEADER, len, dx[7:0], dx[15:8], dy[7:0], dy[15:8], cks, q, ftr};
    endfunction

    task automatic send_frame_bytes(input logic [71:0] fw, input int first, input int last);
        for (int i = first; i <= last; i++)
            send_byte(fw[71 - 8 * i -: 8]);
    endtask

    task automatic send_frame(input logic [15:0] dx, input logic [15:0] dy,
                              input logic [7:0] q, input flaw_t flaw);
        send_frame_bytes(frame_word(dx, dy, q, flaw), 0, 8);
    endtask

    // Drop valid and let every pending result drain before touching the register
    task automatic wait_idle();
        rx_valid = 1'b0;
        while (expected_flows.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_scale(input logic [15:0] value);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        scale_now = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic test_reset_scale();
        // second frame follows the footer directly
        send_frame(16'h8000, 16'h7FFF, 8'h00, FLAW_NONE);
        send_frame(16'h0001, 16'hFFFF, 8'hFF, FLAW_NONE);
        wait_idle();
    endtask

    task automatic test_scale_extremes();
        write_scale(16'hFFFF);
        send_frame(16'h8000, 16'h8000, 8'h5A, FLAW_NONE);
        send_frame(16'h7FFF, 16'hFFFF, 8'hA5, FLAW_NONE);
        wait_idle();
        write_scale(16'h0000);
        send_frame(16'h7FFF, 16'h8000, 8'h81, FLAW_NONE);
        wait_idle();
    endtask

    task automatic test_broken_frames();
        write_scale(16'd1);
        send_frame(16'h1234, 16'hABCD, 8'h11, FLAW_LEN);
        send_frame(16'h00FF, 16'hFF00, 8'h22, FLAW_CKS);
        // good checksum but bad footer: held values change, no result
        send_frame(16'hFFFF, 16'h0101, 8'h33, FLAW_FOOT);
        send_frame(16'h4321, 16'hC0DE, 8'h44, FLAW_NONE);
        // footer right after footer goes back to hunting
        send_byte(ofp_pkg::FRAME_FOOTER);
        send_frame(16'h0F0F, 16'hF0F0, 8'h55, FLAW_NONE);
        send_byte(8'h13);
        send_frame(16'h8001, 16'h7FFE, 8'h66, FLAW_NONE);
        wait_idle();
    endtask

    task automatic test_scale_mid_frame();
        logic [71:0] fw;
        fw = frame_word(16'hE000, 16'h2000, 8'h77, FLAW_NONE);
        send_frame_bytes(fw, 0, 5);
        wait_idle();
        write_scale(16'd40000);
        send_frame_bytes(fw, 6, 8);
        wait_idle();
    endtask

    task automatic test_random_stream();
        int unsigned goal;
        int unsigned nframes;
        int unsigned pick;
        logic [15:0] new_scale;
        goal = rx_count + RANDOM_BYTES;
        while (rx_count < goal)
        begin
            wait_idle();
            case ($urandom_range(0, 5))
                0:       new_scale = 16'h0000;
                1:       new_scale = 16'hFFFF;
                2:       new_scale = ofp_pkg::FLOW_SCALE_RESET;
                default: new_scale = 16'($urandom);
            endcase
            write_scale(new_scale);
            rx_gaps_on   = ($urandom_range(0, 3) != 0);
            out_stall_on = ($urandom_range(0, 3) != 0);
            nframes = $urandom_range(6, 20);
            repeat (nframes)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    // noise, leaning on the header and footer codes
                    repeat ($urandom_range(1, 6))
                    begin
                        case ($urandom_range(0, 3))
                            0:       send_byte(ofp_pkg::FRAME_HEADER);
                            1:       send_byte(ofp_pkg::FRAME_FOOTER);
                            default: send_byte(8'($urandom));
                        endcase
                    end
                end
                else if (pick == 1)
                    send_frame(16'($urandom), 16'($urandom), 8'($urandom),
                               flaw_t'($urandom_range(1, 3)));
                else
                    send_frame(16'($urandom), 16'($urandom), 8'($urandom), FLAW_NONE);
            end
        end
        wait_idle();
    endtask

    // Output side: random stall before each result
    initial
    begin
        int unsigned n;
        flow_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            n = draw_wait(out_stall_on);
            if (n != 0)
            begin
                flow_stall = 1'b1;
                repeat (n) @(negedge clk);
            end
            flow_stall = 1'b0;
            do @(posedge clk); while (!flow_valid);
        end
    end

    task automatic log_fail(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    always @(posedge clk)
    begin
        ofp_pkg::flow_result_t want;
        if (rst_n && flow_valid && !flow_stall)
        begin
            if (expected_flows.size() == 0)
                log_fail($sformatf("unexpected flow result x=%0d y=%0d q=%0d",
                                   flow_x, flow_y, quality));
            else
            begin
                want = expected_flows.pop_front();
                if (flow_x !== want.flow_x || flow_y !== want.flow_y
                    || quality !== want.quality)
                    log_fail($sformatf("flow mismatch: exp x=%0d y=%0d q=%0d, got x=%0d y=%0d q=%0d",
                                       want.flow_x, want.flow_y, want.quality,
                                       flow_x, flow_y, quality));
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        rx_valid     = 1'b0;
        rx_byte      = 8'h00;
        cfg_valid    = 1'b0;
        cfg_data     = 16'h0000;
        rx_gaps_on   = 1'b1;
        out_stall_on = 1'b1;
        rx_count     = 0;
        fail_count   = 0;
        cycle_count  = 0;
        frame_pos    = WANT_HDR;
        scale_now    = ofp_pkg::FLOW_SCALE_RESET;
        held_flow    = '0;
        for (int i = 0; i < 4; i++)
            motion[i] = 8'h00;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_scale();
        test_scale_extremes();
        test_broken_frames();
        test_scale_mid_frame();
        test_random_stream();

        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("tb_optical_flow_frame_parser_top: clean");
        else
            $display("tb_optical_flow_frame_parser_top: errors");
        $finish;
    end

endmodule
